// ----- rtl/bcg_pkg.sv -----
// ---------------------------------------------------------------------------
// bcg_pkg: shared types and constants for the button gesture classifier
// Payload structs, event codes, register indexes and queue sizing.
// ---------------------------------------------------------------------------
package bcg_pkg;

   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DBL_WINDOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESSED_LEVEL = 2'd2;

   localparam logic [15:0] DBL_WINDOW_RESET = 16'd300;
   localparam logic [15:0] LONG_TIME_RESET  = 16'd1000;

   // result queue: four entries, up to two written per cycle
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   typedef enum logic [2:0] {
      EV_PRESS        = 3'd0,
      EV_RELEASE_LONG = 3'd1,
      EV_CLICK        = 3'd2,
      EV_DOUBLE       = 3'd3,
      EV_LONG         = 3'd4
   } event_code_type;

   typedef struct packed {
      logic        pin_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      event_code_type event_code;
      logic           last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] double_click_window;
      logic [15:0] long_press_time;
      logic        pressed_level;
   } cfg_type;

   // events produced by one sample, first event in ev0
   typedef struct packed {
      logic [1:0]     count;
      event_code_type ev0;
      event_code_type ev1;
   } step_result_type;

endpackage

// ----- rtl/bcg_core.sv -----
// ---------------------------------------------------------------------------
// bcg_core: gesture state and per-sample classification
// Holds the button state and turns one registered sample into 0..2 events.
// ---------------------------------------------------------------------------
module bcg_core
   import bcg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  req_type         sample,
   input  cfg_type         cfg,
   output step_result_type result
);

   logic        held_ff, held_in;
   logic [31:0] press_stamp_ff, press_stamp_in;
   logic        long_fired_ff, long_fired_in;
   logic        click_waiting_ff, click_waiting_in;
   logic [31:0] click_stamp_ff, click_stamp_in;
   logic        second_seen_ff, second_seen_in;

   logic [31:0] click_elapsed;
   logic [31:0] hold_elapsed;
   logic        confirm;
   logic        waiting_after;
   logic        is_down;
   logic        long_reached;
   logic        edge_ev_valid;
   event_code_type edge_ev;

   always_comb begin
      click_elapsed = sample.now_ms - click_stamp_ff;
      hold_elapsed  = sample.now_ms - press_stamp_ff;
      confirm       = click_waiting_ff && (click_elapsed >= {16'd0, cfg.double_click_window});
      waiting_after = click_waiting_ff && !confirm;
      is_down       = (sample.pin_level == cfg.pressed_level);
      long_reached  = (hold_elapsed >= {16'd0, cfg.long_press_time});

      held_in          = held_ff;
      press_stamp_in   = press_stamp_ff;
      long_fired_in    = long_fired_ff;
      click_waiting_in = waiting_after;
      click_stamp_in   = click_stamp_ff;
      second_seen_in   = second_seen_ff;
      edge_ev_valid    = 1'b0;
      edge_ev          = EV_PRESS;

      if (is_down && !held_ff) begin
         held_in        = 1'b1;
         press_stamp_in = sample.now_ms;
         long_fired_in  = 1'b0;
         if (waiting_after) begin
            second_seen_in   = 1'b1;
            click_waiting_in = 1'b0;
         end
         edge_ev_valid = 1'b1;
         edge_ev       = EV_PRESS;
      end else if (!is_down && held_ff) begin
         held_in = 1'b0;
         if (!long_fired_ff && !long_reached) begin
            if (second_seen_ff) begin
               second_seen_in   = 1'b0;
               click_waiting_in = 1'b0;
               edge_ev_valid    = 1'b1;
               edge_ev          = EV_DOUBLE;
            end else begin
               click_waiting_in = 1'b1;
               click_stamp_in   = sample.now_ms;
            end
         end else begin
            click_waiting_in = 1'b0;
            second_seen_in   = 1'b0;
            edge_ev_valid    = 1'b1;
            edge_ev          = EV_RELEASE_LONG;
         end
      end else if (held_ff && !long_fired_ff && long_reached) begin
         long_fired_in    = 1'b1;
         click_waiting_in = 1'b0;
         edge_ev_valid    = 1'b1;
         edge_ev          = EV_LONG;
      end

      // pack: a confirmed click always comes first
      result.count = {1'b0, confirm} + {1'b0, edge_ev_valid};
      result.ev0   = confirm ? EV_CLICK : edge_ev;
      result.ev1   = edge_ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff          <= 1'b0;
         press_stamp_ff   <= '0;
         long_fired_ff    <= 1'b0;
         click_waiting_ff <= 1'b0;
         click_stamp_ff   <= '0;
         second_seen_ff   <= 1'b0;
      end else if (step_en) begin
         held_ff          <= held_in;
         press_stamp_ff   <= press_stamp_in;
         long_fired_ff    <= long_fired_in;
         click_waiting_ff <= click_waiting_in;
         click_stamp_ff   <= click_stamp_in;
         second_seen_ff   <= second_seen_in;
      end
   end

endmodule

// ----- rtl/bcg_queue.sv -----
// ---------------------------------------------------------------------------
// bcg_queue: result queue
// Takes up to two results per cycle, hands out one per transfer.
// ---------------------------------------------------------------------------
module bcg_queue
   import bcg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  step_result_type push,
   input  logic            push_en,
   output logic            room_for_two,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_payload
);

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_CNT_W-1:0] push_n;
   logic                   pop;
   logic [QUEUE_PTR_W-1:0] wr_ptr_next;

   always_comb begin
      rsp_valid    = (count_ff != '0);
      push_n       = push_en ? {1'b0, push.count} : '0;
      pop          = rsp_valid && rsp_ready;
      wr_ptr_next  = wr_ptr_ff + 1'b1;
      wr_ptr_in    = wr_ptr_ff + push_n[QUEUE_PTR_W-1:0];
      rd_ptr_in    = rd_ptr_ff + {{(QUEUE_PTR_W-1){1'b0}}, pop};
      count_in     = count_ff + push_n - {{(QUEUE_CNT_W-1){1'b0}}, pop};
      room_for_two = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
      rsp_payload  = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push_en && push.count != 2'd0) begin
         entry_ff[wr_ptr_ff].event_code <= push.ev0;
         entry_ff[wr_ptr_ff].last       <= (push.count == 2'd1);
      end
      if (push_en && push.count == 2'd2) begin
         entry_ff[wr_ptr_next].event_code <= push.ev1;
         entry_ff[wr_ptr_next].last       <= 1'b1;
      end
   end

endmodule

// ----- rtl/button_click_gesture_classifier.sv -----
// ---------------------------------------------------------------------------
// button_click_gesture_classifier: press / click / double click / long press
// Classifies timestamped pin samples into button gesture events.
// ---------------------------------------------------------------------------
// Each sample (pin level, millisecond tick) is captured in an input register,
// classified when the queue has room for two results, and its 0, 1 or 2 events
// land in a four-entry result queue. One sample is taken every cycle while
// the queue holds at most two results; each result leaves in a cycle of its
// own through the single queue read port, so a sample that yields two events
// (a timed-out click followed by the edge event) leaves as two transfers. The
// last flag marks the final event of a sample; samples with no event produce
// no transfer. Elapsed times are modulo 2^32. Registers are written through
// csr_* with no wait; the user must write them only while no sample is in
// flight, as the block itself does not enforce it.
// ---------------------------------------------------------------------------
module button_click_gesture_classifier
   import bcg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg_ff;
   req_type         sample_ff;
   logic            sample_valid_ff, sample_valid_in;
   logic            advance;
   logic            room_for_two;
   step_result_type step_result;

   // Advance the held sample only when the queue can absorb a two-event sample.
   assign advance         = sample_valid_ff && room_for_two;
   assign req_ready       = !sample_valid_ff || room_for_two;
   assign sample_valid_in = req_ready ? req_valid : sample_valid_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_click_window <= DBL_WINDOW_RESET;
         cfg_ff.long_press_time     <= LONG_TIME_RESET;
         cfg_ff.pressed_level       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DBL_WINDOW:    cfg_ff.double_click_window <= csr_wdata;
            CSR_LONG_TIME:     cfg_ff.long_press_time     <= csr_wdata;
            CSR_PRESSED_LEVEL: cfg_ff.pressed_level       <= csr_wdata[0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // Input register: hold the sample until the classifier takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff <= 1'b0;
      end else begin
         sample_valid_ff <= sample_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         sample_ff <= req_payload;
      end
   end

   bcg_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .sample  (sample_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   bcg_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (step_result),
      .push_en      (advance),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for button_click_gesture_classifier
// A scripted run walks the gesture cases with fixed answers, then several
// register settings follow, each with randomized press/release traffic.
// Every result transfer is checked against the script's answer or the in-bench predictor.
// ---------------------------------------------------------------------------
module testbench;
   import bcg_pkg::*;

   localparam int UNTYPED         = -1;    // row answer comes from the predictor
   localparam int PIPE_SETTLE     = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int REPORT_LIMIT    = 10;

   // one scripted row: either a register setting or a sample with its answer
   typedef struct {
      logic           is_cfg;
      cfg_type        cfg;
      req_type        sample;
      int             n_events;
      event_code_type ev_first;
      event_code_type ev_second;
   } script_row_type;

   // one randomized stretch of traffic under fixed register values
   typedef struct {
      cfg_type cfg;
      bit      tx_idle;
      bit      rx_idle;
      bit      hold_off;
      int      items;
   } cfg_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_DBL_WINDOW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // answer typed into the script, travels alongside the payload
   int             fixed_n = UNTYPED;
   event_code_type fixed_first = EV_PRESS;
   event_code_type fixed_second = EV_PRESS;

   // predictor copy of the registers, reset values
   logic [15:0] win_ms   = DBL_WINDOW_RESET;
   logic [15:0] long_ms  = LONG_TIME_RESET;
   logic        down_lvl = 1'b0;

   // predictor copy of the gesture state
   logic        btn_held      = 1'b0;
   logic [31:0] press_ms      = '0;
   logic        long_done     = 1'b0;
   logic        click_pending = 1'b0;
   logic [31:0] click_ms      = '0;
   logic        double_armed  = 1'b0;

   rsp_type pending_events[$];
   int      error_count  = 0;
   int      quiet_cycles = 0;

   // receiver control; each hold-off request bumps the count
   bit tx_idle      = 1'b1;
   bit rx_idle      = 1'b1;
   int hold_off_req = 0;

   // random traffic state
   logic [31:0] tick_ms;
   logic        last_pin = 1'b1;

   button_click_gesture_classifier u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hold reset, then release it on a falling edge.
   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Gesture predictor: one sample in, zero to two events out, in the order
   // the block reports them. A timed-out click is confirmed before the edge
   // or hold handling of the same sample.
   // ------------------------------------------------------------------------
   function automatic void classify_sample(input req_type s, output int n,
                                           output event_code_type ev_a,
                                           output event_code_type ev_b);
      logic           is_down;
      logic [31:0]    since_click;
      logic [31:0]    held_for;
      event_code_type evs [2];
      n       = 0;
      evs[0]  = EV_PRESS;
      evs[1]  = EV_PRESS;
      is_down = (s.pin_level == down_lvl);
      since_click = s.now_ms - click_ms;
      held_for    = s.now_ms - press_ms;

      // close a click window that has run out
      if (click_pending && since_click >= {16'd0, win_ms}) begin
         click_pending = 1'b0;
         evs[n] = EV_CLICK;
         n++;
      end

      if (is_down && !btn_held) begin
         btn_held  = 1'b1;
         press_ms  = s.now_ms;
         long_done = 1'b0;
         // a press inside an open window arms the double click
         if (click_pending && since_click < {16'd0, win_ms}) begin
            double_armed  = 1'b1;
            click_pending = 1'b0;
         end
         evs[n] = EV_PRESS;
         n++;
      end else if (!is_down && btn_held) begin
         btn_held = 1'b0;
         if (!long_done && held_for < {16'd0, long_ms}) begin
            if (double_armed) begin
               double_armed  = 1'b0;
               click_pending = 1'b0;
               evs[n] = EV_DOUBLE;
               n++;
            end else begin
               click_pending = 1'b1;
               click_ms      = s.now_ms;
            end
         end else begin
            click_pending = 1'b0;
            double_armed  = 1'b0;
            evs[n] = EV_RELEASE_LONG;
            n++;
         end
      end else if (btn_held && !long_done) begin
         if (held_for >= {16'd0, long_ms}) begin
            long_done     = 1'b1;
            click_pending = 1'b0;
            evs[n] = EV_LONG;
            n++;
         end
      end
      ev_a = evs[0];
      ev_b = evs[1];
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   // ------------------------------------------------------------------------
   // Transfer monitor: check results first, then predict from the accepted
   // sample. A sample's results never leave in its own acceptance cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_transfers
      int             n;
      event_code_type ev_a;
      event_code_type ev_b;
      rsp_type        want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               flag_error($sformatf("unexpected result: code=%0d last=%0b",
                                    rsp_payload.event_code, rsp_payload.last));
            end else begin
               want = pending_events.pop_front();
               if (rsp_payload.event_code !== want.event_code ||
                   rsp_payload.last !== want.last) begin
                  flag_error($sformatf(
                     "result mismatch: expected code=%0d last=%0b, got code=%0d last=%0b",
                     want.event_code, want.last, rsp_payload.event_code,
                     rsp_payload.last));
               end
            end
         end
         if (req_valid && req_ready) begin
            // always advance the predictor so its state stays in step
            classify_sample(req_payload, n, ev_a, ev_b);
            if (fixed_n != UNTYPED) begin
               n    = fixed_n;
               ev_a = fixed_first;
               ev_b = fixed_second;
            end
            if (n > 0) begin
               want.event_code = ev_a;
               want.last       = (n == 1);
               pending_events.push_back(want);
            end
            if (n > 1) begin
               want.event_code = ev_b;
               want.last       = 1'b1;
               pending_events.push_back(want);
            end
         end
      end
   end

   // Watchdog: end the run after a long stretch with no transfer at all.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int burst_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: random stalls while rx_idle is set, ready held high otherwise.
   // A new hold-off request drops ready for a long, counted stretch so the
   // result queue fills and the block stalls its input.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int stall_left;
      int hold_served;
      stall_left  = 0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_off_req) begin
            hold_served = hold_off_req;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (rx_idle && $urandom_range(0, 3) == 0) stall_left = burst_len();
         end
      end
   end

   // Offer one sample; enter and leave on a falling edge. Drop valid only
   // when a gap is taken, so valid is never lowered and raised in one step.
   task automatic offer_sample(input req_type s, input int n,
                               input event_code_type ev_a,
                               input event_code_type ev_b);
      int gap;
      gap = (tx_idle && $urandom_range(0, 2) == 0) ? burst_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_payload  <= s;
      fixed_n      <= n;
      fixed_first  <= ev_a;
      fixed_second <= ev_b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering and wait for every expected result, then let any sample
   // that causes no result clear the pipeline.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Program all three registers and mirror them in the predictor.
   task automatic program_settings(input cfg_type c);
      write_reg(CSR_DBL_WINDOW, c.double_click_window);
      write_reg(CSR_LONG_TIME, c.long_press_time);
      write_reg(CSR_PRESSED_LEVEL, CSR_DATA_W'(c.pressed_level));
      win_ms   = c.double_click_window;
      long_ms  = c.long_press_time;
      down_lvl = c.pressed_level;
   endtask

   function automatic script_row_type sample_row(input logic pin, input logic [31:0] now,
                                                 input int n,
                                                 input event_code_type ev_a = EV_PRESS,
                                                 input event_code_type ev_b = EV_PRESS);
      script_row_type r;
      r.is_cfg           = 1'b0;
      r.cfg              = '0;
      r.sample.pin_level = pin;
      r.sample.now_ms    = now;
      r.n_events         = n;
      r.ev_first         = ev_a;
      r.ev_second        = ev_b;
      return r;
   endfunction

   function automatic script_row_type cfg_row(input logic [15:0] win,
                                              input logic [15:0] lt,
                                              input logic lvl);
      script_row_type r;
      r = sample_row(1'b0, '0, UNTYPED);
      r.is_cfg                  = 1'b1;
      r.cfg.double_click_window = win;
      r.cfg.long_press_time     = lt;
      r.cfg.pressed_level       = lvl;
      return r;
   endfunction

   function automatic cfg_phase_type make_phase(input logic [15:0] win,
                                                input logic [15:0] lt,
                                                input logic lvl, input bit tx, input bit rx,
                                                input bit hold, input int items);
      cfg_phase_type p;
      p.cfg.double_click_window = win;
      p.cfg.long_press_time     = lt;
      p.cfg.pressed_level       = lvl;
      p.tx_idle  = tx;
      p.rx_idle  = rx;
      p.hold_off = hold;
      p.items    = items;
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // Random gesture traffic. Most samples advance time by a step that is zero,
   // small, random or picked near the window or the long-press threshold and
   // usually flip the pin, which forms press/release pairs that hit both sides
   // of each boundary. The rest jump to a random tick or step back in time.
   // ------------------------------------------------------------------------
   function automatic req_type next_gesture_sample();
      req_type     s;
      logic [31:0] step;
      logic [31:0] span;
      int          pick;
      pick = $urandom_range(0, 99);
      span = (win_ms > long_ms) ? {16'd0, win_ms} : {16'd0, long_ms};
      if (pick < 85) begin
         case ($urandom_range(0, 5))
            0: step = '0;
            1: step = $urandom_range(1, 20);
            2: step = {16'd0, win_ms} + $urandom_range(0, 2) - 32'd1;
            3: step = {16'd0, long_ms} + $urandom_range(0, 2) - 32'd1;
            4: step = $urandom_range(0, 2 * span + 2);
            default: step = $urandom_range(1, 200);
         endcase
         tick_ms = tick_ms + step;
         s.pin_level = ($urandom_range(0, 9) < 7) ? ~last_pin : last_pin;
      end else if (pick < 95) begin
         tick_ms = $urandom();
         s.pin_level = 1'($urandom_range(0, 1));
      end else begin
         tick_ms = tick_ms - $urandom_range(1, 50);
         s.pin_level = 1'($urandom_range(0, 1));
      end
      s.now_ms = tick_ms;
      last_pin = s.pin_level;
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      script_row_type script [$];
      cfg_phase_type  phases [$];

      // Reset registers first: window 300, long press 1000, pressed when low.
      script = '{
         sample_row(1'b1, 32'd0,    0),                    // idle after reset
         sample_row(1'b0, 32'd10,   1, EV_PRESS),
         sample_row(1'b1, 32'd600,  0),                    // short release opens window
         sample_row(1'b1, 32'd900,  1, EV_CLICK),          // window runs out exactly
         sample_row(1'b0, 32'd1000, 1, EV_PRESS),
         sample_row(1'b1, 32'd1100, 0),
         sample_row(1'b0, 32'd1399, 1, EV_PRESS),          // second press one ms early
         sample_row(1'b1, 32'd1450, 1, EV_DOUBLE),
         sample_row(1'b0, 32'd2000, 1, EV_PRESS),
         sample_row(1'b0, 32'd2999, 0),                    // one ms short of long
         sample_row(1'b0, 32'd3000, 1, EV_LONG),
         sample_row(1'b1, 32'd3001, 1, EV_RELEASE_LONG),
         sample_row(1'b0, 32'd3100, 1, EV_PRESS),
         sample_row(1'b1, 32'd4100, 1, EV_RELEASE_LONG),   // released right at long time
         sample_row(1'b0, 32'd4200, 1, EV_PRESS),
         sample_row(1'b1, 32'd4250, 0),
         sample_row(1'b0, 32'd4550, 2, EV_CLICK, EV_PRESS), // click then press
         // wrap of the millisecond tick, and a stamp from the future
         sample_row(1'b1, 32'hFFFF_FF00, UNTYPED),
         sample_row(1'b0, 32'hFFFF_FFF0, UNTYPED),
         sample_row(1'b1, 32'h0000_0010, UNTYPED),
         sample_row(1'b0, 32'h0000_0005, UNTYPED),
         sample_row(1'b1, 32'h0000_0006, UNTYPED),
         sample_row(1'b1, 32'hFFFF_FFFF, 1, EV_CLICK),
         // zero long time, pressed when high
         cfg_row(16'd0, 16'd0, 1'b1),
         sample_row(1'b1, 32'd100, 1, EV_PRESS),
         sample_row(1'b1, 32'd100, 1, EV_LONG),            // long on the next held sample
         sample_row(1'b0, 32'd101, 1, EV_RELEASE_LONG),
         sample_row(1'b1, 32'd200, 1, EV_PRESS),
         sample_row(1'b0, 32'd200, 1, EV_RELEASE_LONG),    // zero-length press
         // zero window confirms a click on the very next sample
         cfg_row(16'd0, 16'd5, 1'b1),
         sample_row(1'b1, 32'd300, 1, EV_PRESS),
         sample_row(1'b0, 32'd301, 0),
         sample_row(1'b0, 32'd301, 1, EV_CLICK)
      };

      phases = '{
         make_phase(DBL_WINDOW_RESET, LONG_TIME_RESET, 1'b0, 1'b1, 1'b1, 1'b0, 250),
         make_phase(16'd1, 16'd1, 1'b1, 1'b1, 1'b1, 1'b0, 200),
         make_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 200),
         make_phase(16'd0, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0, 150),
         make_phase(16'($urandom_range(20, 400)), 16'($urandom_range(50, 1500)),
                    1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0, 250),
         make_phase(16'($urandom_range(5, 200)), 16'($urandom_range(5, 300)),
                    1'($urandom_range(0, 1)), 1'b0, 1'b1, 1'b1, 300),
         make_phase(16'd0, 16'd20, 1'b0, 1'b0, 1'b1, 1'b0, 150),
         make_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                    1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0, 350)
      };

      tick_ms = $urandom();
      do @(negedge clock); while (reset);

      // Scripted part, starting from the reset register values.
      foreach (script[i]) begin
         if (script[i].is_cfg) begin
            settle_pipeline();
            program_settings(script[i].cfg);
         end else begin
            offer_sample(script[i].sample, script[i].n_events,
                         script[i].ev_first, script[i].ev_second);
         end
      end

      // Random part, one register setting per phase. Each phase starts
      // only after the previous one has drained completely.
      foreach (phases[p]) begin
         settle_pipeline();
         program_settings(phases[p].cfg);
         tx_idle = phases[p].tx_idle;
         rx_idle = phases[p].rx_idle;
         for (int k = 0; k < phases[p].items; k++) begin
            // keep offering while the receiver holds off
            if (phases[p].hold_off && k == phases[p].items / 3) hold_off_req++;
            offer_sample(next_gesture_sample(), UNTYPED, EV_PRESS, EV_PRESS);
         end
      end

      settle_pipeline();
      if (error_count == 0 && pending_events.size() == 0) begin
         $display("PASS");
      end else begin
         $display("errors: %0d, results still expected: %0d", error_count,
                  pending_events.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bcg_pkg.sv
rtl/bcg_core.sv
rtl/bcg_queue.sv
rtl/button_click_gesture_classifier.sv
tb/testbench.sv
